// ===== rtl/brms_pkg.sv =====
// Package for the bucketed RMS level meter: field widths, rate limits and
// the transaction payload types. Depends on nothing.
package brms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W = 18;
  localparam int BNUM_W = 12;
  localparam int FRAMES_W = 14;
  localparam int RMS_W = 17;

  localparam int RATE_MAX = 192000;
  localparam int RATE_RESET = 48000;

  // Bucket lengths advance by a remainder modulo this base.
  localparam int MOD_BASE = 1000;
  localparam int REM_W = 10;

  // 4*sum/frames never exceeds 4*2^30, so the quotient needs 33 bits.
  localparam int QUO_W = 33;
  localparam int ROOT_ITERS = 17;
  localparam int SREM_W = 19;

  localparam int DEF_MAX_BUCKETS = 4096;
  localparam int DEF_BUCKET_MS = 50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_block;
  } brms_in_t;

  typedef struct packed {
    logic [BNUM_W-1:0]   bucket_number;
    logic [FRAMES_W-1:0] frames_in_bucket;
    logic [RMS_W-1:0]    rms_level;
  } brms_out_t;

endpackage

// ===== rtl/bucketed_rms_level_meter_unit.sv =====
// Top level of the bucketed RMS level meter: serial squarer, accumulator,
// restoring divider and digit-by-digit square root. Depends on brms_pkg.
//
// Each accepted sample is squared by a shift-add multiplier that takes one
// multiplier bit per cycle; a sample that does not close a bucket then
// passes the check state before the block returns to idle for the next one.
// A sample that closes a bucket adds a restoring division of 4*sum by the
// frame count (one quotient bit per cycle), a square root that first loads
// its operand and then retires two operand bits per cycle, and a load of
// the result register.
// The result register holds one finished transaction, so the next sample is
// taken while a result still waits; a second bucket end waits for it to go.
// After reset and after each sample_rate write, the bucket stride is divided
// by 1000 one bit per cycle, and in_stall stays high until that division ends.
module bucketed_rms_level_meter_unit #(
  parameter int MAX_BUCKETS = brms_pkg::DEF_MAX_BUCKETS,
  parameter int BUCKET_MS = brms_pkg::DEF_BUCKET_MS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  brms_pkg::brms_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output brms_pkg::brms_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [brms_pkg::RATE_W-1:0]   cfg_wdata
);
  import brms_pkg::*;

  localparam int STRIDE_W = $clog2(RATE_MAX * BUCKET_MS + 1);
  localparam int LEN_W = $clog2(RATE_MAX * BUCKET_MS / MOD_BASE + 2);
  localparam int SUM_W = 2 * SAMPLE_W - 2 + LEN_W;
  localparam int DIV_W = SUM_W + 2;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int BKT_W = $clog2(MAX_BUCKETS + 1);
  localparam int MCAND_W = 2 * SAMPLE_W - 1;

  typedef enum logic [2:0] {
    ST_CFG_LOAD,
    ST_CFG_DIV,
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RATE_W-1:0]     rate_r;
  logic [STRIDE_W-1:0]   cdiv_r;
  logic [REM_W-1:0]      crem_r;
  logic [REM_W-1:0]      lrem_r;
  logic [BKT_W-1:0]      bucket_r;
  logic [LEN_W-1:0]      frame_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SAMPLE_W-1:0]   mplier_r;
  logic [MCAND_W-1:0]    mcand_r;
  logic [DIV_W-1:0]      div_r;
  logic [LEN_W-1:0]      drem_r;
  logic [2*ROOT_ITERS-1:0] sq_op_r;
  logic [RMS_W-1:0]      root_r;
  logic [SREM_W-1:0]     srem_r;
  logic                  out_valid_r;
  brms_out_t             out_data_r;

  logic [RATE_W-1:0]     rate_clamped;
  logic [REM_W:0]        crem_trial;
  logic [REM_W:0]        lrem_sum;
  logic                  len_carry;
  logic [LEN_W:0]        len_raw;
  logic [LEN_W:0]        bucket_len;
  logic [LEN_W:0]        frame_inc;
  logic [LEN_W:0]        drem_trial;
  logic [SREM_W+1:0]     srem_trial;
  logic [SREM_W+1:0]     root_trial;
  logic [SAMPLE_W-1:0]   in_mag;
  logic                  exhausted;

  always_comb begin
    if (cfg_wdata == '0) begin
      rate_clamped = RATE_W'(1);
    end else if (cfg_wdata > RATE_W'(RATE_MAX)) begin
      rate_clamped = RATE_W'(RATE_MAX);
    end else begin
      rate_clamped = cfg_wdata;
    end
  end

  assign crem_trial = {crem_r, cdiv_r[STRIDE_W-1]};

  assign lrem_sum = {1'b0, lrem_r} + {1'b0, crem_r};
  assign len_carry = (lrem_sum >= (REM_W+1)'(MOD_BASE));
  assign len_raw = {1'b0, cdiv_r[LEN_W-1:0]} + (LEN_W+1)'(len_carry);
  assign bucket_len = (len_raw == '0) ? (LEN_W+1)'(1) : len_raw;
  assign frame_inc = {1'b0, frame_r} + (LEN_W+1)'(1);

  assign drem_trial = {drem_r, div_r[DIV_W-1]};

  assign srem_trial = {srem_r, sq_op_r[2*ROOT_ITERS-1 -: 2]};
  assign root_trial = (SREM_W+2)'({root_r, 2'b01});

  assign in_mag = in_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_data.sample)
                                             : SAMPLE_W'(in_data.sample);
  assign exhausted = (bucket_r >= BKT_W'(MAX_BUCKETS));

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CFG_LOAD;
      cnt_r <= '0;
      rate_r <= RATE_W'(RATE_RESET);
      lrem_r <= '0;
      bucket_r <= '0;
      frame_r <= '0;
      sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        rate_r <= rate_clamped;
        lrem_r <= '0;
        bucket_r <= '0;
        frame_r <= '0;
        sum_r <= '0;
        state_r <= ST_CFG_LOAD;
      end else begin
        case (state_r)
          ST_CFG_LOAD: begin
            cdiv_r <= STRIDE_W'(STRIDE_W'(rate_r) * STRIDE_W'(BUCKET_MS));
            crem_r <= '0;
            cnt_r <= '0;
            state_r <= ST_CFG_DIV;
          end
          ST_CFG_DIV: begin
            if (crem_trial >= (REM_W+1)'(MOD_BASE)) begin
              crem_r <= REM_W'(crem_trial - (REM_W+1)'(MOD_BASE));
              cdiv_r <= {cdiv_r[STRIDE_W-2:0], 1'b1};
            end else begin
              crem_r <= crem_trial[REM_W-1:0];
              cdiv_r <= {cdiv_r[STRIDE_W-2:0], 1'b0};
            end
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(STRIDE_W - 1)) begin
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_valid && !exhausted) begin
              mplier_r <= in_mag;
              mcand_r <= MCAND_W'(in_mag);
              cnt_r <= '0;
              state_r <= ST_MUL;
            end
          end
          ST_MUL: begin
            if (mplier_r[0]) begin
              sum_r <= sum_r + SUM_W'(mcand_r);
            end
            mplier_r <= mplier_r >> 1;
            mcand_r <= mcand_r << 1;
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(SAMPLE_W - 1)) begin
              state_r <= ST_CHK;
            end
          end
          ST_CHK: begin
            frame_r <= frame_inc[LEN_W-1:0];
            if (frame_inc >= bucket_len) begin
              div_r <= {sum_r, 2'b00};
              drem_r <= '0;
              cnt_r <= '0;
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_IDLE;
            end
          end
          ST_DIV: begin
            if (drem_trial >= {1'b0, frame_r}) begin
              drem_r <= LEN_W'(drem_trial - {1'b0, frame_r});
              div_r <= {div_r[DIV_W-2:0], 1'b1};
            end else begin
              drem_r <= drem_trial[LEN_W-1:0];
              div_r <= {div_r[DIV_W-2:0], 1'b0};
            end
            if (cnt_r == CNT_W'(DIV_W - 1)) begin
              cnt_r <= '0;
              state_r <= ST_SQRT;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
          ST_SQRT: begin
            if (cnt_r == '0) begin
              sq_op_r <= (2*ROOT_ITERS)'(div_r[QUO_W-1:0]);
              root_r <= '0;
              srem_r <= '0;
              cnt_r <= CNT_W'(1);
            end else begin
              if (srem_trial >= root_trial) begin
                srem_r <= SREM_W'(srem_trial - root_trial);
                root_r <= {root_r[RMS_W-2:0], 1'b1};
              end else begin
                srem_r <= SREM_W'(srem_trial);
                root_r <= {root_r[RMS_W-2:0], 1'b0};
              end
              sq_op_r <= sq_op_r << 2;
              cnt_r <= cnt_r + CNT_W'(1);
              if (cnt_r == CNT_W'(ROOT_ITERS)) begin
                state_r <= ST_OUT;
              end
            end
          end
          ST_OUT: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r <= 1'b1;
              out_data_r.bucket_number <= BNUM_W'(bucket_r);
              out_data_r.frames_in_bucket <= FRAMES_W'(frame_r);
              out_data_r.rms_level <= root_r;
              bucket_r <= bucket_r + BKT_W'(1);
              frame_r <= '0;
              sum_r <= '0;
              lrem_r <= len_carry ? REM_W'(lrem_sum - (REM_W+1)'(MOD_BASE))
                                  : lrem_sum[REM_W-1:0];
              state_r <= ST_IDLE;
            end
          end
          default: begin
            state_r <= ST_CFG_LOAD;
          end
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/brms_level_checker.sv =====
// Checker for the bucketed RMS level meter: watches the sample, result and
// rate-write ports, predicts each completed bucket and compares it with the
// result transaction that the block emits. Depends on brms_pkg.
module brms_level_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  brms_pkg::brms_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  brms_pkg::brms_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [brms_pkg::RATE_W-1:0]   cfg_wdata,
  output int unsigned                   mismatches,
  output int unsigned                   awaiting
);
  import brms_pkg::*;

  logic [RATE_W-1:0]   rate_q;
  logic [12:0]         bucket_idx;
  logic [FRAMES_W-1:0] frames_acc;
  logic [43:0]         energy_acc;
  logic [REM_W-1:0]    stride_rem;
  logic [FRAMES_W-1:0] span_len;
  brms_out_t           levels_q[$];

  function automatic logic [31:0] stride_part(input logic [RATE_W-1:0] r);
    logic [31:0] stride;
    stride = 32'(r) * 32'(DEF_BUCKET_MS);
    return stride % 32'(MOD_BASE);
  endfunction

  function automatic logic [FRAMES_W-1:0] span_of(input logic [RATE_W-1:0] r,
                                                  input logic [REM_W-1:0] rem);
    logic [31:0] len;
    len = (32'(r) * 32'(DEF_BUCKET_MS)) / 32'(MOD_BASE);
    if (32'(rem) + stride_part(r) >= 32'(MOD_BASE)) len = len + 32'(1);
    if (len == 0) len = 32'(1);
    return len[FRAMES_W-1:0];
  endfunction

  function automatic logic [RMS_W-1:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = RMS_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[RMS_W-1:0];
  endfunction

  task automatic meter_restart();
    bucket_idx = '0;
    frames_acc = '0;
    energy_acc = '0;
    stride_rem = '0;
    span_len = span_of(rate_q, '0);
  endtask

  task automatic meter_set_rate(input logic [RATE_W-1:0] v);
    logic [RATE_W-1:0] r;
    r = v;
    if (r == 0) r = RATE_W'(1);
    if (r > RATE_W'(RATE_MAX)) r = RATE_W'(RATE_MAX);
    rate_q = r;
    meter_restart();
  endtask

  task automatic meter_take_sample(input brms_in_t item);
    int          s;
    logic [63:0] mean4;
    brms_out_t   want;
    if (bucket_idx >= 13'(DEF_MAX_BUCKETS)) return;
    s = int'(item.sample);
    energy_acc = energy_acc + 44'(s * s);
    frames_acc = frames_acc + FRAMES_W'(1);
    if (frames_acc < span_len) return;
    mean4 = (64'(energy_acc) << 2) / 64'(frames_acc);
    want.bucket_number = bucket_idx[BNUM_W-1:0];
    want.frames_in_bucket = frames_acc;
    want.rms_level = root_floor(mean4);
    levels_q = {levels_q, want};
    bucket_idx = bucket_idx + 13'(1);
    frames_acc = '0;
    energy_acc = '0;
    stride_rem = REM_W'((32'(stride_rem) + stride_part(rate_q)) % 32'(MOD_BASE));
    span_len = span_of(rate_q, stride_rem);
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want,
                        input int unsigned bucket);
    mismatches = mismatches + 1;
    $display("mismatch %s: got %0d, want %0d (bucket %0d)", what, got, want, bucket);
  endtask

  task automatic check_result(input brms_out_t got);
    brms_out_t want;
    if (levels_q.size() == 0) begin
      report("unexpected transaction", 32'(got.bucket_number), 0, 32'(got.bucket_number));
      return;
    end
    want = levels_q.pop_front();
    if (got.bucket_number != want.bucket_number)
      report("bucket_number", 32'(got.bucket_number), 32'(want.bucket_number),
             32'(want.bucket_number));
    if (got.frames_in_bucket != want.frames_in_bucket)
      report("frames_in_bucket", 32'(got.frames_in_bucket), 32'(want.frames_in_bucket),
             32'(want.bucket_number));
    if (got.rms_level != want.rms_level)
      report("rms_level", 32'(got.rms_level), 32'(want.rms_level),
             32'(want.bucket_number));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      levels_q.delete();
      rate_q = RATE_W'(RATE_RESET);
      meter_restart();
    end else begin
      if (cfg_we) meter_set_rate(cfg_wdata);
      if (in_valid && !in_stall) meter_take_sample(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    awaiting <= levels_q.size();
  end

endmodule

// ===== tb/sv/tb_bucketed_rms_level_meter_unit.sv =====
// Testbench top for the bucketed RMS level meter: drives samples, rate writes
// and receiver stalls, and gives the verdict from the checker's mismatch count.
// Depends on brms_pkg, bucketed_rms_level_meter_unit and brms_level_checker.
module tb_bucketed_rms_level_meter_unit;
  import brms_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 75;
  localparam int LOUD_RATE = 800;
  localparam int LOUD_ITEMS = 40;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  brms_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  brms_out_t         out_data;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;
  int unsigned       mismatches;
  int unsigned       awaiting;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       hold_serial;
  int unsigned       cycle_count;

  logic signed [SAMPLE_W-1:0] edge_vals [16] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh0002, 16'shFFFE, 16'sh4000,
    16'shC000, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh7FFE, 16'sh8001, 16'sh0100
  };

  bucketed_rms_level_meter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  brms_level_checker u_level_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[bucketed_rms_level_meter_unit] ERROR");
    $finish;
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(7))
      0: return FULL_NEG;
      1: return FULL_POS;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] draw_rate();
    if ($urandom_range(3) == 0) return RATE_W'($urandom_range(3000, 401));
    return RATE_W'($urandom_range(400, 1));
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic lob);
    int       gap;
    brms_in_t item;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.sample = s;
    item.last_of_block = lob;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_random(input int count);
    repeat (count) push_sample(draw_sample(), 1'($urandom_range(1)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    hold_serial <= 0;
    recv_stall_pct <= 0;
    send_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A partial bucket at the reset rate, dropped by the next rate write.
    push_random(40);
    settle();

    // A zero rate acts as one sample per bucket, so each edge value is a bucket.
    write_rate('0);
    foreach (edge_vals[i]) push_sample(edge_vals[i], 1'(i % 2));
    settle();

    // Results pile up behind a long receiver hold-off until the input stalls.
    write_rate(RATE_W'(20));
    hold_serial <= hold_serial + 1;
    push_random(40);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 59; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      write_rate(draw_rate());
      push_random(PHASE_ITEMS);
      settle();
    end

    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // One bucket at full scale, then an oversized rate that must saturate.
    write_rate(RATE_W'(LOUD_RATE));
    repeat (LOUD_ITEMS) push_sample(FULL_NEG, 1'($urandom_range(1)));
    settle();
    write_rate('1);
    push_random(12);
    settle();

    // A rate write restarts bucketing from a partial bucket.
    write_rate(RATE_W'(5));
    push_random(12);
    settle();

    if (mismatches == 0) begin
      $display("[bucketed_rms_level_meter_unit] OK");
    end else begin
      $display("[bucketed_rms_level_meter_unit] ERROR");
    end
    $finish;
  end

endmodule
